// ===== sv/mmpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpq_pkg
// Shared types, codes and helpers for the move-multiple execution block.
// ----------------------------------------------------------------------------
package mmpq_pkg;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FETCH = 8'b0000_0010,
    ST_DEC   = 8'b0000_0100,
    ST_EA2   = 8'b0000_1000,
    ST_EA3   = 8'b0001_0000,
    ST_XFER  = 8'b0010_0000,
    ST_WB    = 8'b0100_0000,
    ST_RDM   = 8'b1000_0000
  } state_t;

  localparam logic [2:0] OP_EXEC   = 3'd0;
  localparam logic [2:0] OP_WR_MEM = 3'd1;
  localparam logic [2:0] OP_RD_MEM = 3'd2;
  localparam logic [2:0] OP_WR_REG = 3'd3;
  localparam logic [2:0] OP_RD_REG = 3'd4;

  localparam logic [4:0] SEL_PC    = 5'd16;
  localparam logic [4:0] SEL_FLAGS = 5'd17;

  localparam logic [2:0] MODE_IND   = 3'd2;
  localparam logic [2:0] MODE_POST  = 3'd3;
  localparam logic [2:0] MODE_PRE   = 3'd4;
  localparam logic [2:0] MODE_DISP  = 3'd5;
  localparam logic [2:0] MODE_INDEX = 3'd6;
  localparam logic [2:0] MODE_EXT   = 3'd7;

  localparam logic [2:0] EXT_ABS_W  = 3'd0;
  localparam logic [2:0] EXT_ABS_L  = 3'd1;
  localparam logic [2:0] EXT_PC_D   = 3'd2;
  localparam logic [2:0] EXT_PC_X   = 3'd3;

  localparam int IN_BYTES  = 7;
  localparam int OUT_BYTES = 9;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = v[15] ? (32'hffff0000 | {16'h0, v}) : {16'h0, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    sext8 = v[7] ? (32'hffffff00 | {24'h0, v}) : {24'h0, v};
  endfunction

endpackage

// ===== sv/mmpq_ram.sv =====
// ----------------------------------------------------------------------------
// mmpq_ram
// Byte-wide single-port memory with registered read data.
// ----------------------------------------------------------------------------
module mmpq_ram #(
  parameter int MEM_BYTES = 4096,
  parameter int AW        = $clog2(MEM_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/move_multiple_peripheral_quick_exec.sv =====
// ----------------------------------------------------------------------------
// move_multiple_peripheral_quick_exec
// MOVEQ / MOVEP / MOVEM execution over a byte memory, with register file,
// program counter and flags, plus direct memory and register access items.
// ----------------------------------------------------------------------------
// channel | dir | fields (tdata, low bit up)
// in_     | in  | operation[2:0] mem_address[14:3] reg_select[19:15] write_value[51:20]
// out_    | out | read_value[31:0] pc_after[63:32] status[64]
//
// memory write, register read and write items finish in idle, memory read in ST_RDM
// execute: fetch, decode, EA2/EA3 as the mode needs, transfer (not MOVEQ), writeback
// transfer: store writes each byte, load issues each byte read then takes the data back
// (registered ram read); clear mask bits are skipped; all through the single byte port
// reset: synchronous active low, registers, pc and flags cleared, ram not cleared
// in_tready low while an item is at work; output register frees the input side
// ----------------------------------------------------------------------------
module move_multiple_peripheral_quick_exec #(
  parameter int MEM_BYTES = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // operation, mem_address, reg_select, write_value
  input  logic [mmpq_pkg::IN_BYTES*8-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // read_value, pc_after, status
  output logic [mmpq_pkg::OUT_BYTES*8-1:0]     out_tdata
);
  import mmpq_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  state_t      state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  ib_r [8];
  logic [7:0]  ib_nxt [8];
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  i_r, i_nxt;
  logic [1:0]  bc_r, bc_nxt;
  logic        ph_r, ph_nxt;
  logic [31:0] sh_r, sh_nxt;
  logic [31:0] rf_r [16];
  logic [31:0] pc_r, pc_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic        out_valid_r;
  logic [31:0] out_rv_r, out_pc_r;
  logic        out_st_r;

  logic [2:0]  in_op;
  logic [11:0] in_maddr;
  logic [4:0]  in_sel;
  logic [31:0] in_wv;
  logic        acc_in;

  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [7:0]    m_wdata, m_rdata;

  logic [3:0]  rd_idx;
  logic [31:0] rd_val;
  logic        rf_we;
  logic [3:0]  rf_widx;
  logic [31:0] rf_wdata;

  logic [31:0] add_a, add_b, sum;

  logic        fin, fin_st;
  logic [31:0] fin_rv, fin_pc;

  logic [7:0]  hi, lo;
  logic [2:0]  mode, rn;
  logic        is_moveq, is_movep, is_movem, movem_ok, to_regs, lng, predec, load;
  logic        ext_pcd;
  logic [15:0] mask;
  logic [3:0]  len;
  logic [31:0] step;
  logic [1:0]  nbm1, bsel;
  logic [3:0]  xreg;
  logic [31:0] sh_new, ld_val, idx_val;
  logic [31:0] maddr32;

  assign in_op    = in_tdata[2:0];
  assign in_maddr = in_tdata[14:3];
  assign in_sel   = in_tdata[19:15];
  assign in_wv    = in_tdata[51:20];
  assign maddr32  = {20'h0, in_maddr};

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign acc_in    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'h0, out_st_r, out_pc_r, out_rv_r};

  mmpq_ram #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (m_we),
    .addr  (m_addr),
    .wdata (m_wdata),
    .rdata (m_rdata)
  );

  // decode of the fetched instruction bytes
  assign hi       = ib_r[0];
  assign lo       = ib_r[1];
  assign mode     = lo[5:3];
  assign rn       = lo[2:0];
  assign to_regs  = hi[2];
  assign lng      = lo[6];
  assign is_moveq = (hi & 8'hf1) == 8'h70;
  assign is_movep = ((hi & 8'hf1) == 8'h01) && ((lo & 8'h38) == 8'h08);
  assign is_movem = ((hi & 8'hfb) == 8'h48) && lo[7];
  assign predec   = !is_movep && (mode == MODE_PRE);
  assign load     = is_movep ? !lo[7] : to_regs;
  assign mask     = is_movep ? 16'h0001 : {ib_r[2], ib_r[3]};
  assign nbm1     = lng ? 2'd3 : 2'd1;
  assign ext_pcd  = (mode == MODE_EXT) && (rn == EXT_PC_D);
  assign xreg     = is_movep ? {1'b0, hi[3:1]} : (predec ? ~i_r : i_r);
  assign bsel     = predec ? bc_r : (nbm1 - bc_r);
  assign sh_new   = {sh_r[23:0], m_rdata};

  always_comb begin
    movem_ok = 1'b0;
    len      = 4'd4;
    case (mode)
      MODE_IND:   movem_ok = 1'b1;
      MODE_POST:  movem_ok = to_regs;
      MODE_PRE:   movem_ok = !to_regs;
      MODE_DISP:  begin movem_ok = 1'b1; len = 4'd6; end
      MODE_INDEX: begin movem_ok = 1'b1; len = 4'd6; end
      MODE_EXT: begin
        case (rn)
          EXT_ABS_W: begin movem_ok = 1'b1; len = 4'd6; end
          EXT_ABS_L: begin movem_ok = 1'b1; len = 4'd8; end
          EXT_PC_D:  begin movem_ok = to_regs; len = 4'd6; end
          EXT_PC_X:  begin movem_ok = to_regs; len = 4'd6; end
          default:   movem_ok = 1'b0;
        endcase
      end
      default: movem_ok = 1'b0;
    endcase
    if (is_moveq) begin
      len = 4'd2;
    end else if (is_movep) begin
      len = 4'd4;
    end
  end

  always_comb begin
    if (is_movep) begin
      step = 32'd2;
    end else if (predec) begin
      step = 32'hffffffff;
    end else begin
      step = 32'd1;
    end
  end

  assign rd_val  = rf_r[rd_idx];
  assign idx_val = ib_r[4][3] ? rd_val : sext16(rd_val[15:0]);

  always_comb begin
    if (is_movep && !lng) begin
      ld_val = {rd_val[31:16], sh_new[15:0]};
    end else if (lng) begin
      ld_val = sh_new;
    end else begin
      ld_val = sext16(sh_new[15:0]);
    end
  end

  // shared adder
  assign sum = add_a + add_b;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ib_nxt    = ib_r;
    acc_nxt   = acc_r;
    i_nxt     = i_r;
    bc_nxt    = bc_r;
    ph_nxt    = ph_r;
    sh_nxt    = sh_r;
    pc_nxt    = pc_r;
    flags_nxt = flags_r;
    m_we      = 1'b0;
    m_addr    = acc_r[AW-1:0];
    m_wdata   = 8'h0;
    rd_idx    = in_sel[3:0];
    rf_we     = 1'b0;
    rf_widx   = xreg;
    rf_wdata  = ld_val;
    add_a     = acc_r;
    add_b     = step;
    fin       = 1'b0;
    fin_rv    = 32'h0;
    fin_pc    = pc_r;
    fin_st    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        rd_idx = in_sel[3:0];
        m_addr = maddr32[AW-1:0];
        if (acc_in) begin
          case (in_op)
            OP_EXEC: begin
              cnt_nxt   = 4'd0;
              state_nxt = ST_FETCH;
            end
            OP_WR_MEM: begin
              m_we    = 1'b1;
              m_wdata = in_wv[7:0];
              fin     = 1'b1;
            end
            OP_RD_MEM: begin
              state_nxt = ST_RDM;
            end
            OP_WR_REG: begin
              fin = 1'b1;
              if (!in_sel[4]) begin
                rf_we    = 1'b1;
                rf_widx  = in_sel[3:0];
                rf_wdata = in_wv;
              end else if (in_sel == SEL_PC) begin
                pc_nxt = in_wv;
                fin_pc = in_wv;
              end else if (in_sel == SEL_FLAGS) begin
                flags_nxt = in_wv[3:0];
              end
            end
            OP_RD_REG: begin
              fin = 1'b1;
              if (!in_sel[4]) begin
                fin_rv = rd_val;
              end else if (in_sel == SEL_PC) begin
                fin_rv = pc_r;
              end else if (in_sel == SEL_FLAGS) begin
                fin_rv = {28'h0, flags_r};
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end

      ST_RDM: begin
        fin       = 1'b1;
        fin_rv    = {24'h0, m_rdata};
        state_nxt = ST_IDLE;
      end

      ST_FETCH: begin
        add_a  = pc_r;
        add_b  = {28'h0, cnt_r};
        m_addr = sum[AW-1:0];
        if (cnt_r != 4'd0) begin
          ib_nxt[3'(cnt_r - 4'd1)] = m_rdata;
        end
        if (cnt_r == 4'd8) begin
          state_nxt = ST_DEC;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end

      ST_DEC: begin
        rd_idx = {1'b1, rn};
        i_nxt  = 4'd0;
        bc_nxt = 2'd0;
        ph_nxt = 1'b0;
        add_a  = rd_val;
        add_b  = 32'h0;
        if (is_moveq) begin
          rf_we     = 1'b1;
          rf_widx   = {1'b0, hi[3:1]};
          rf_wdata  = sext8(lo);
          flags_nxt = {lo[7], lo == 8'h0, 2'b00};
          state_nxt = ST_WB;
        end else if (is_movep) begin
          add_b     = sext16({ib_r[2], ib_r[3]});
          acc_nxt   = sum;
          state_nxt = ST_XFER;
        end else if (is_movem && movem_ok) begin
          state_nxt = ST_XFER;
          if (mode == MODE_DISP) begin
            add_b = sext16({ib_r[4], ib_r[5]});
          end else if (mode == MODE_INDEX) begin
            state_nxt = ST_EA2;
          end else if (mode == MODE_EXT) begin
            add_a = 32'h0;
            if (rn == EXT_ABS_W) begin
              add_b = sext16({ib_r[4], ib_r[5]});
            end else if (rn == EXT_ABS_L) begin
              add_b = {ib_r[4], ib_r[5], ib_r[6], ib_r[7]};
            end else begin
              add_a     = pc_r;
              add_b     = 32'd4;
              state_nxt = ST_EA2;
            end
          end
          acc_nxt = sum;
        end else begin
          fin       = 1'b1;
          fin_st    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_EA2: begin
        add_b   = ext_pcd ? sext16({ib_r[4], ib_r[5]}) : sext8(ib_r[5]);
        acc_nxt = sum;
        state_nxt = ext_pcd ? ST_XFER : ST_EA3;
      end

      ST_EA3: begin
        rd_idx    = {ib_r[4][7], ib_r[4][6:4]};
        add_b     = idx_val;
        acc_nxt   = sum;
        state_nxt = ST_XFER;
      end

      ST_XFER: begin
        rd_idx = xreg;
        if (!mask[i_r]) begin
          if (i_r == 4'd15) begin
            state_nxt = ST_WB;
          end else begin
            i_nxt = i_r + 4'd1;
          end
        end else if (!load) begin
          m_we   = 1'b1;
          m_addr = predec ? sum[AW-1:0] : acc_r[AW-1:0];
          case (bsel)
            2'd0:    m_wdata = rd_val[7:0];
            2'd1:    m_wdata = rd_val[15:8];
            2'd2:    m_wdata = rd_val[23:16];
            default: m_wdata = rd_val[31:24];
          endcase
          acc_nxt = sum;
          if (bc_r == nbm1) begin
            bc_nxt = 2'd0;
            if (i_r == 4'd15 || is_movep) begin
              state_nxt = ST_WB;
            end else begin
              i_nxt = i_r + 4'd1;
            end
          end else begin
            bc_nxt = bc_r + 2'd1;
          end
        end else if (!ph_r) begin
          // issue the byte read, data comes back next cycle
          m_addr  = acc_r[AW-1:0];
          acc_nxt = sum;
          ph_nxt  = 1'b1;
        end else begin
          sh_nxt = sh_new;
          ph_nxt = 1'b0;
          if (bc_r == nbm1) begin
            bc_nxt = 2'd0;
            rf_we  = 1'b1;
            if (i_r == 4'd15 || is_movep) begin
              state_nxt = ST_WB;
            end else begin
              i_nxt = i_r + 4'd1;
            end
          end else begin
            bc_nxt = bc_r + 2'd1;
          end
        end
      end

      ST_WB: begin
        add_a  = pc_r;
        add_b  = {28'h0, len};
        pc_nxt = sum;
        // address register write-back wins over a loaded value
        if (is_movem && (mode == MODE_POST || mode == MODE_PRE)) begin
          rf_we    = 1'b1;
          rf_widx  = {1'b1, rn};
          rf_wdata = acc_r;
        end
        fin       = 1'b1;
        fin_pc    = sum;
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 4'd0;
      i_r         <= 4'd0;
      bc_r        <= 2'd0;
      ph_r        <= 1'b0;
      pc_r        <= 32'h0;
      flags_r     <= 4'h0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 16; k++) begin
        rf_r[k] <= 32'h0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      bc_r    <= bc_nxt;
      ph_r    <= ph_nxt;
      pc_r    <= pc_nxt;
      flags_r <= flags_nxt;
      if (rf_we) begin
        rf_r[rf_widx] <= rf_wdata;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ib_r  <= ib_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    if (fin) begin
      out_rv_r <= fin_rv;
      out_pc_r <= fin_pc;
      out_st_r <= fin_st;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE)
    else $error("in_tready high outside idle");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (!out_valid_r || out_tready))
    else $error("result overwrites an untaken item");

  a_fetch_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH && cnt_r == 4'd8) |=> state_r == ST_DEC)
    else $error("fetch did not hand over to decode");

  a_exec_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && in_op == OP_EXEC) |=> (state_r == ST_FETCH && cnt_r == 4'd0))
    else $error("execute item did not start fetch");

endmodule
